### sv/amc_pkg.sv
// shared constants and types of the affine matrix concatenation block
package amc_pkg;

   // cell layout of one 3x4 matrix
   localparam int unsigned CELLS = 12;
   localparam int unsigned IDX_W = 4;
   localparam int unsigned FIELD_W = 32;

   localparam logic [IDX_W-1:0] LAST_CELL = 4'd11;
   localparam logic [1:0] ROW_LAST = 2'd2;
   localparam logic [1:0] COL_LAST = 2'd3;
   localparam logic [1:0] K_LAST = 2'd2;
   localparam logic [1:0] TRANS_COL = 2'd3;

   // matrix select codes
   localparam logic SEL_LEFT = 1'b0;
   localparam logic SEL_RIGHT = 1'b1;

   // command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one classified request
   typedef struct packed {
      logic                      write_en;
      logic                      which_matrix;
      logic [IDX_W-1:0]          cell_index;
      logic signed [FIELD_W-1:0] cell_value;
      logic                      compute;
   } amc_cmd_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PROD,
      ST_ACC,
      ST_TRANS,
      ST_OUT
   } amc_state_type;

endpackage

### sv/amc_chan_if.sv
// request and response channel interfaces
interface amc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               which_matrix;
   logic [amc_pkg::IDX_W-1:0]          cell_index;
   logic signed [amc_pkg::FIELD_W-1:0] cell_value;
   logic                               compute;

   modport source(output valid, which_matrix, cell_index, cell_value, compute,
                  input ready);
   modport sink(input valid, which_matrix, cell_index, cell_value, compute,
                output ready);
endinterface

interface amc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [amc_pkg::IDX_W-1:0]          out_index;
   logic signed [amc_pkg::FIELD_W-1:0] out_value;
   logic                               saturated;
   logic                               last_cell;

   modport source(output valid, out_index, out_value, saturated, last_cell,
                  input ready);
   modport sink(input valid, out_index, out_value, saturated, last_cell,
                output ready);
endinterface

### sv/amc_front.sv
// front end: accepts requests and classifies them into queue commands
module amc_front (
   amc_req_if.sink               req_bus,
   input  logic                  queue_full,
   output logic                  cmd_push,
   output amc_pkg::amc_cmd_type  cmd
);
   import amc_pkg::*;

   // accept whenever the queue has room
   assign req_bus.ready = !queue_full;
   assign cmd_push = req_bus.valid && !queue_full;

   // out-of-range cell indexes turn into commands that write no cell
   always_comb begin
      cmd.write_en = req_bus.cell_index < IDX_W'(CELLS);
      cmd.which_matrix = req_bus.which_matrix;
      cmd.cell_index = req_bus.cell_index;
      cmd.cell_value = req_bus.cell_value;
      cmd.compute = req_bus.compute;
   end

endmodule

### sv/amc_queue.sv
// short command queue between front and back end
module amc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_push,
   input  amc_pkg::amc_cmd_type  push_cmd,
   output logic                  queue_full,
   input  logic                  cmd_pop,
   output logic                  head_valid,
   output amc_pkg::amc_cmd_type  head_cmd
);
   import amc_pkg::*;

   amc_cmd_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // status
   assign queue_full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = cmd_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + CNT_W'(cmd_push) - CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (cmd_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/amc_back.sv
// back end: matrix storage, shared multiply-accumulate sequencer, response register
module amc_back #(
   parameter int FRAC_BITS = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  amc_pkg::amc_cmd_type  head_cmd,
   output logic                  cmd_pop,
   amc_rsp_if.source             rsp_bus
);
   import amc_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int HW = (VW + 1) / 2;
   localparam int BHW = VW - HW;
   localparam int PPW = VW + HW + 1;
   localparam int PW = 2 * VW;
   localparam int AW = 2 * VW + 2;

   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW - 1){1'b0}}};
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW - 1){1'b1}}};

   logic signed [VW-1:0] left_ff [CELLS];
   logic signed [VW-1:0] right_ff [CELLS];

   amc_state_type state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic [1:0] k_ff, k_in;
   logic signed [PPW-1:0] pp_ff, pp_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [AW-1:0]  acc_ff, acc_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_index_ff, rsp_index_in;
   logic signed [FIELD_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_sat_ff, rsp_sat_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                  wr_left, wr_right;
   logic signed [VW-1:0]  wr_val;
   logic [IDX_W-1:0]      lidx, ridx;
   logic signed [VW-1:0]  op_a, op_b;
   logic [HW-1:0]         b_lo;
   logic signed [BHW-1:0] b_hi;
   logic signed [PPW-1:0] mul_b, mul;
   logic                  fits;
   logic signed [VW-1:0]  sat_val;
   logic                  out_free;

   // operand fetch: left row element (or translation term), right column element
   always_comb begin
      lidx = (state_ff == ST_TRANS) ? {row_ff, TRANS_COL} : {row_ff, k_ff};
      ridx = {k_ff, col_ff};
      op_a = left_ff[lidx];
      op_b = right_ff[ridx];
      b_lo = op_b[HW-1:0];
      b_hi = op_b[VW-1:HW];
   end

   // shared multiplier, one half of the right operand per cycle
   always_comb begin
      mul_b = (state_ff == ST_MUL_HI) ? PPW'(b_hi) : PPW'($signed({1'b0, b_lo}));
      mul = PPW'(op_a) * mul_b;
   end

   // saturation of the finished cell sum
   always_comb begin
      fits = (&acc_ff[AW-1:VW-1]) | ~(|acc_ff[AW-1:VW-1]);
      if (fits) begin
         sat_val = acc_ff[VW-1:0];
      end else if (acc_ff[AW-1]) begin
         sat_val = VAL_MIN;
      end else begin
         sat_val = VAL_MAX;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign wr_val = VW'($signed(head_cmd.cell_value));

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      k_in = k_ff;
      pp_in = pp_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      cmd_pop = 1'b0;
      wr_left = 1'b0;
      wr_right = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               cmd_pop = 1'b1;
               wr_left = head_cmd.write_en && head_cmd.which_matrix == SEL_LEFT;
               wr_right = head_cmd.write_en && head_cmd.which_matrix == SEL_RIGHT;
               if (head_cmd.compute) begin
                  row_in = '0;
                  col_in = '0;
                  k_in = '0;
                  acc_in = '0;
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: begin
            pp_in = mul;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in = PW'(pp_ff);
            pp_in = mul;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            prod_in = prod_ff + (PW'(pp_ff) <<< HW);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + AW'(prod_ff >>> FRAC_BITS);
            if (k_ff == K_LAST) begin
               k_in = '0;
               state_in = (col_ff == TRANS_COL) ? ST_TRANS : ST_OUT;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = ST_MUL_LO;
            end
         end
         ST_TRANS: begin
            acc_in = acc_ff + AW'(op_a);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = {row_ff, col_ff};
               rsp_value_in = FIELD_W'(sat_val);
               rsp_sat_in = !fits;
               rsp_last_in = {row_ff, col_ff} == LAST_CELL;
               acc_in = '0;
               if (col_ff == COL_LAST) begin
                  col_in = '0;
                  if (row_ff == ROW_LAST) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in = row_ff + 2'd1;
                     state_in = ST_MUL_LO;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
                  state_in = ST_MUL_LO;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= '0;
         col_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and response payload registers
   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_last_ff <= rsp_last_in;
   end

   // matrix cells, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            left_ff[i] <= '0;
            right_ff[i] <= '0;
         end
      end else begin
         if (wr_left) begin
            left_ff[head_cmd.cell_index] <= wr_val;
         end
         if (wr_right) begin
            right_ff[head_cmd.cell_index] <= wr_val;
         end
      end
   end

   // response channel
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_index = rsp_index_ff;
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.saturated = rsp_sat_ff;
   assign rsp_bus.last_cell = rsp_last_ff;

endmodule

### sv/affine_matrix_concat.sv
// top level of the affine 3x4 matrix concatenation block
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    which_matrix, cell_index, cell_value, compute
//   rsp_bus   out  valid/ready    out_index, out_value, saturated, last_cell
//
// a request is queued (two entries) and applied by the back end once its sequencer is idle.
// a compute request then runs 12 cells through one shared multiplier: per cell, for
// each k a low-half multiply, high-half multiply, product and accumulate step, then a
// translation add in the last column and the output step; a response stall holds the sequencer at that cell.
// reset is synchronous and clears both matrices, the queue and the response valid flag.
module affine_matrix_concat #(
   parameter int FRAC_BITS = 16,
   parameter int VALUE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   amc_req_if.sink    req_bus,
   amc_rsp_if.source  rsp_bus
);
   import amc_pkg::*;

   amc_cmd_type push_cmd;
   amc_cmd_type head_cmd;
   logic        cmd_push;
   logic        cmd_pop;
   logic        queue_full;
   logic        head_valid;

   // request classification
   amc_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd)
   );

   // decoupling queue
   amc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd_push   (cmd_push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .cmd_pop    (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // storage and multiply-accumulate sequencer
   amc_back #(
      .FRAC_BITS   (FRAC_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .cmd_pop    (cmd_pop),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTHESIS
   // the back end only takes a command that is there
   pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> head_valid)
      else $error("command popped from empty queue");

   // last cell marker matches the final cell position
   last_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last_cell == (rsp_bus.out_index == LAST_CELL)))
      else $error("last_cell does not match out_index");

   // no response right after reset
   quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");
`endif

endmodule
